// ===== src/cmbd_pkg.sv =====
// Shared constants, types and store geometry for the console memory bus decoder.
package cmbd_pkg;

  // Store sizes in bytes
  localparam int RAM_BYTES     = 2097152;
  localparam int ROM_BYTES     = 524288;
  localparam int PORT_BYTES    = 65536;
  localparam int SCRATCH_BYTES = 4096;

  // Byte offset widths
  localparam int RAM_AW  = $clog2(RAM_BYTES);
  localparam int ROM_AW  = $clog2(ROM_BYTES);
  localparam int PORT_AW = $clog2(PORT_BYTES);
  localparam int SCR_AW  = $clog2(SCRATCH_BYTES);

  // Each store is four byte lanes; a row holds one byte per lane
  localparam int RAM_ROWS  = RAM_BYTES / 4;
  localparam int ROM_ROWS  = ROM_BYTES / 4;
  localparam int PORT_ROWS = PORT_BYTES / 4;
  localparam int SCR_ROWS  = SCRATCH_BYTES / 4;
  localparam int RAM_RW    = RAM_AW - 2;
  localparam int ROM_RW    = ROM_AW - 2;
  localparam int PORT_RW   = PORT_AW - 2;
  localparam int SCR_RW    = SCR_AW - 2;

  // Widest offset over all stores
  localparam int AW_A  = (RAM_AW > ROM_AW) ? RAM_AW : ROM_AW;
  localparam int AW_B  = (PORT_AW > SCR_AW) ? PORT_AW : SCR_AW;
  localparam int OFF_W = (AW_A > AW_B) ? AW_A : AW_B;
  localparam int ROW_W = OFF_W - 2;

  // Clearing sweep covers the deepest zero-reset store
  localparam int CLR_A    = (RAM_ROWS > ROM_ROWS) ? RAM_ROWS : ROM_ROWS;
  localparam int CLR_ROWS = (CLR_A > PORT_ROWS) ? CLR_A : PORT_ROWS;
  localparam int CLR_W    = $clog2(CLR_ROWS);

  // Queue between decode and access
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Opcodes and size codes
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;
  localparam logic [1:0] SZ_BYTE    = 2'd0;
  localparam logic [1:0] SZ_HALF    = 2'd1;

  // Memory map
  localparam logic [15:0] PAGE_SCR    = 16'h1f80;
  localparam logic [15:0] PAGE_PAR    = 16'h1f00;
  localparam logic [15:0] SCR_LIMIT   = 16'h1000;
  localparam logic [15:0] SEG_MASK    = 16'hff80;
  localparam logic [15:0] SEG_KUSEG   = 16'h0000;
  localparam logic [15:0] SEG_KSEG0   = 16'h8000;
  localparam logic [15:0] SEG_KSEG1   = 16'ha000;
  localparam logic [15:0] BIOS_MASK   = 16'hfff8;
  localparam logic [15:0] BIOS_KUSEG  = 16'h1fc0;
  localparam logic [15:0] BIOS_KSEG0  = 16'h9fc0;
  localparam logic [15:0] BIOS_KSEG1  = 16'hbfc0;

  // RAM write control register
  localparam logic [31:0] CTRL_ADDR  = 32'hfffe0130;
  localparam logic [31:0] CTRL_OFF_A = 32'h0000_0800;
  localparam logic [31:0] CTRL_OFF_B = 32'h0000_0804;
  localparam logic [31:0] CTRL_ON_A  = 32'h0000_0000;
  localparam logic [31:0] CTRL_ON_B  = 32'h0001_e988;

  typedef enum logic [2:0] {
    TGT_RAM  = 3'd0,
    TGT_PAR  = 3'd1,
    TGT_SCR  = 3'd2,
    TGT_HW   = 3'd3,
    TGT_BIOS = 3'd4,
    TGT_NONE = 3'd5
  } tgt_t;

  // Decoded access, one per queue entry
  typedef struct packed {
    tgt_t                       tgt;
    logic                       rd;
    logic                       we;
    logic                       ram_on;
    logic [1:0]                 off_lo;
    logic [3:0]                 byte_on;
    logic [3:0]                 lane_on;
    logic [3:0][ROW_W-1:0]      lane_row;
    logic [3:0][7:0]            lane_wdata;
  } cmd_t;

  // Access unit status
  typedef struct packed {
    logic clearing;
    logic issue;
  } bk_stat_t;

endpackage

// ===== src/console_memory_bus_decoder.sv =====
// Top level of the console memory bus decoder: front end, command queue and access unit.
//
//   Channel | Direction | Handshake            | Beat
//   in_     | input     | in_valid / in_stall  | opcode, access_size, address, write_data
//   out_    | output    | out_valid / out_stall| read_data, target, write_applied, ram_writes_on
//
// An access passes the store access and then the result register in the access unit, and a
// new access issues only once the last one has left the response state and out_stall allows it.
// The two-entry queue keeps taking beats while a result waits on out_stall.
// After reset the access unit sweeps RAM, BIOS and parallel store to zero, one row of
// four bytes per cycle over max(RAM, BIOS, parallel bytes) / 4 rows, 524288 as built;
// in_stall stays high for the whole sweep.
module console_memory_bus_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic [2:0]  out_target,
  output logic        out_write_applied,
  output logic        out_ram_writes_on
);

  cmbd_pkg::cmd_t      fe_cmd;
  cmbd_pkg::cmd_t      q_head;
  cmbd_pkg::bk_stat_t  stat;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                in_acc;

  // Input beat accepted only after the clearing sweep and with queue room
  assign in_stall = stat.clearing || q_full;
  assign in_acc   = in_valid && !in_stall;

  cmbd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .opcode      (in_opcode),
    .access_size (in_access_size),
    .address     (in_address),
    .write_data  (in_write_data),
    .cmd         (fe_cmd)
  );

  cmbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_acc),
    .push_cmd (fe_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  cmbd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .res_valid         (out_valid),
    .res_stall         (out_stall),
    .res_read_data     (out_read_data),
    .res_target        (out_target),
    .res_write_applied (out_write_applied),
    .res_ram_writes_on (out_ram_writes_on),
    .stat              (stat)
  );

  // A result follows an issue of the access unit by way of its response state
  a_res_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.issue, 2))
    else $error("result without a matching issue");

  // No store issue during the clearing sweep
  a_no_issue_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !stat.issue && !q_valid)
    else $error("access issued during clearing sweep");

  // Forwarded and unmapped accesses never touch a store
  a_no_store_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_target == cmbd_pkg::TGT_HW || out_target == cmbd_pkg::TGT_NONE)
      |-> !out_write_applied && out_read_data == 32'h0)
    else $error("store effect on forwarded or unmapped access");

  // An applied RAM write requires RAM writes on
  a_ram_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_applied && out_target == cmbd_pkg::TGT_RAM |-> out_ram_writes_on)
    else $error("RAM write applied while RAM writes off");

endmodule

// ===== src/cmbd_front.sv =====
// Front end: classifies one beat, lays it out on byte lanes and tracks RAM write enable.
module cmbd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [1:0]       opcode,
  input  logic [1:0]       access_size,
  input  logic [31:0]      address,
  input  logic [31:0]      write_data,
  output cmbd_pkg::cmd_t   cmd
);

  logic                         ram_we_r;
  logic                         ram_we_nxt;
  logic [15:0]                  page;
  logic [15:0]                  pofs;
  cmbd_pkg::tgt_t               tgt;
  logic [cmbd_pkg::OFF_W-1:0]   off;
  logic [cmbd_pkg::ROW_W-1:0]   row_mask;
  logic [cmbd_pkg::ROW_W-1:0]   base_row;
  logic [3:0]                   byte_on;
  logic                         we;
  logic [1:0]                   kk;
  logic                         carry;

  assign page = address[31:16];
  assign pofs = address[15:0];

  // Target decode
  always_comb begin
    if (opcode == cmbd_pkg::OP_PRELOAD) begin
      tgt = cmbd_pkg::TGT_BIOS;
    end else if (page == cmbd_pkg::PAGE_SCR) begin
      tgt = (pofs < cmbd_pkg::SCR_LIMIT) ? cmbd_pkg::TGT_SCR : cmbd_pkg::TGT_HW;
    end else if (page == cmbd_pkg::PAGE_PAR) begin
      tgt = cmbd_pkg::TGT_PAR;
    end else if ((page & cmbd_pkg::SEG_MASK) == cmbd_pkg::SEG_KUSEG ||
                 (page & cmbd_pkg::SEG_MASK) == cmbd_pkg::SEG_KSEG0 ||
                 (page & cmbd_pkg::SEG_MASK) == cmbd_pkg::SEG_KSEG1) begin
      tgt = cmbd_pkg::TGT_RAM;
    end else if ((page & cmbd_pkg::BIOS_MASK) == cmbd_pkg::BIOS_KUSEG ||
                 (page & cmbd_pkg::BIOS_MASK) == cmbd_pkg::BIOS_KSEG0 ||
                 (page & cmbd_pkg::BIOS_MASK) == cmbd_pkg::BIOS_KSEG1) begin
      tgt = cmbd_pkg::TGT_BIOS;
    end else begin
      tgt = cmbd_pkg::TGT_NONE;
    end
  end

  // Offset within the selected store, mirrored by its size
  always_comb begin
    case (tgt)
      cmbd_pkg::TGT_RAM: begin
        off      = cmbd_pkg::OFF_W'(address[cmbd_pkg::RAM_AW-1:0]);
        row_mask = cmbd_pkg::ROW_W'(cmbd_pkg::RAM_ROWS - 1);
      end
      cmbd_pkg::TGT_PAR: begin
        off      = cmbd_pkg::OFF_W'(address[cmbd_pkg::PORT_AW-1:0]);
        row_mask = cmbd_pkg::ROW_W'(cmbd_pkg::PORT_ROWS - 1);
      end
      cmbd_pkg::TGT_SCR: begin
        off      = cmbd_pkg::OFF_W'(address[cmbd_pkg::SCR_AW-1:0]);
        row_mask = cmbd_pkg::ROW_W'(cmbd_pkg::SCR_ROWS - 1);
      end
      cmbd_pkg::TGT_BIOS: begin
        off      = cmbd_pkg::OFF_W'(address[cmbd_pkg::ROM_AW-1:0]);
        row_mask = cmbd_pkg::ROW_W'(cmbd_pkg::ROM_ROWS - 1);
      end
      default: begin
        off      = '0;
        row_mask = '0;
      end
    endcase
  end

  assign base_row = off[cmbd_pkg::OFF_W-1:2];

  // Bytes covered; preload is always a word
  always_comb begin
    if (opcode == cmbd_pkg::OP_PRELOAD) begin
      byte_on = 4'b1111;
    end else begin
      case (access_size)
        cmbd_pkg::SZ_BYTE: byte_on = 4'b0001;
        cmbd_pkg::SZ_HALF: byte_on = 4'b0011;
        default:           byte_on = 4'b1111;
      endcase
    end
  end

  // Store write decision and RAM write control register
  always_comb begin
    we = (opcode == cmbd_pkg::OP_PRELOAD) ||
         (opcode == cmbd_pkg::OP_WRITE &&
          (tgt == cmbd_pkg::TGT_PAR || tgt == cmbd_pkg::TGT_SCR ||
           (tgt == cmbd_pkg::TGT_RAM && ram_we_r)));
    ram_we_nxt = ram_we_r;
    if (opcode == cmbd_pkg::OP_WRITE && !we && access_size[1] &&
        address == cmbd_pkg::CTRL_ADDR) begin
      if (write_data == cmbd_pkg::CTRL_OFF_A || write_data == cmbd_pkg::CTRL_OFF_B) begin
        ram_we_nxt = 1'b0;
      end else if (write_data == cmbd_pkg::CTRL_ON_A ||
                   write_data == cmbd_pkg::CTRL_ON_B) begin
        ram_we_nxt = 1'b1;
      end
    end
  end

  // Lane layout: lane j holds byte (j - base) of the access, wrapping into the next row
  always_comb begin
    cmd.tgt     = tgt;
    cmd.rd      = (opcode == cmbd_pkg::OP_READ) &&
                  (tgt == cmbd_pkg::TGT_RAM || tgt == cmbd_pkg::TGT_PAR ||
                   tgt == cmbd_pkg::TGT_SCR || tgt == cmbd_pkg::TGT_BIOS);
    cmd.we      = we;
    cmd.ram_on  = ram_we_nxt;
    cmd.off_lo  = off[1:0];
    cmd.byte_on = byte_on;
    for (int j = 0; j < 4; j++) begin
      kk    = 2'(j) - off[1:0];
      carry = (2'(j) < off[1:0]);
      cmd.lane_on[j]    = byte_on[kk];
      cmd.lane_wdata[j] = write_data[{kk, 3'b000} +: 8];
      cmd.lane_row[j]   = (base_row + {{(cmbd_pkg::ROW_W-1){1'b0}}, carry}) & row_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_we_r <= 1'b1;
    end else if (accept) begin
      ram_we_r <= ram_we_nxt;
    end
  end

endmodule

// ===== src/cmbd_queue.sv =====
// Two-entry command queue between the decode front end and the access unit.
module cmbd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cmbd_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output cmbd_pkg::cmd_t  head
);

  cmbd_pkg::cmd_t               ent_r [cmbd_pkg::Q_DEPTH];
  logic [cmbd_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [cmbd_pkg::Q_AW-1:0]    wr_ptr_nxt;
  logic [cmbd_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [cmbd_pkg::Q_AW-1:0]    rd_ptr_nxt;
  logic [cmbd_pkg::Q_AW:0]      cnt_r;
  logic [cmbd_pkg::Q_AW:0]      cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (cnt_r == (cmbd_pkg::Q_AW + 1)'(cmbd_pkg::Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/cmbd_back.sv =====
// Access unit: byte-lane stores, clearing sweep after reset, result assembly and output register.
module cmbd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmbd_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [31:0]         res_read_data,
  output logic [2:0]          res_target,
  output logic                res_write_applied,
  output logic                res_ram_writes_on,
  output cmbd_pkg::bk_stat_t  stat
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RESP  = 3'b100
  } bk_state_t;

  bk_state_t                    state_r;
  bk_state_t                    state_nxt;
  logic [cmbd_pkg::CLR_W-1:0]   clr_row_r;
  logic [cmbd_pkg::CLR_W-1:0]   clr_row_nxt;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [31:0]                  out_rd_r;
  cmbd_pkg::tgt_t               out_tgt_r;
  logic                         out_wa_r;
  logic                         out_on_r;
  cmbd_pkg::cmd_t               cur_r;
  logic                         issue;
  logic                         clr_act;
  logic                         ram_clr_in;
  logic                         rom_clr_in;
  logic                         par_clr_in;
  logic                         h_ram;
  logic                         h_par;
  logic                         h_scr;
  logic                         h_rom;
  logic [7:0]                   lane_rd [4];
  logic [31:0]                  rd_nxt;

  assign clr_act = (state_r == ST_CLEAR);
  assign issue   = (state_r == ST_IDLE) && q_valid && (!out_valid_r || !res_stall);
  assign q_pop   = issue;

  // Sweep row falls inside each zero-reset store
  assign ram_clr_in = ({1'b0, clr_row_r} < (cmbd_pkg::CLR_W + 1)'(cmbd_pkg::RAM_ROWS));
  assign rom_clr_in = ({1'b0, clr_row_r} < (cmbd_pkg::CLR_W + 1)'(cmbd_pkg::ROM_ROWS));
  assign par_clr_in = ({1'b0, clr_row_r} < (cmbd_pkg::CLR_W + 1)'(cmbd_pkg::PORT_ROWS));

  assign h_ram = (q_head.tgt == cmbd_pkg::TGT_RAM);
  assign h_par = (q_head.tgt == cmbd_pkg::TGT_PAR);
  assign h_scr = (q_head.tgt == cmbd_pkg::TGT_SCR);
  assign h_rom = (q_head.tgt == cmbd_pkg::TGT_BIOS);

  // Byte lanes of every store
  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic [7:0]                   ram_m [cmbd_pkg::RAM_ROWS];
    logic [7:0]                   par_m [cmbd_pkg::PORT_ROWS];
    logic [7:0]                   scr_m [cmbd_pkg::SCR_ROWS];
    logic [7:0]                   rom_m [cmbd_pkg::ROM_ROWS];
    logic [7:0]                   ram_q;
    logic [7:0]                   par_q;
    logic [7:0]                   scr_q;
    logic [7:0]                   rom_q;
    logic                         lane_wr;
    logic [cmbd_pkg::RAM_RW-1:0]  ram_wa;
    logic [cmbd_pkg::PORT_RW-1:0] par_wa;
    logic [cmbd_pkg::ROM_RW-1:0]  rom_wa;
    logic                         ram_we;
    logic                         par_we;
    logic                         rom_we;
    logic [7:0]                   wd;

    assign lane_wr = issue && q_head.we && q_head.lane_on[j];
    assign wd      = clr_act ? 8'h00 : q_head.lane_wdata[j];
    assign ram_wa  = clr_act ? clr_row_r[cmbd_pkg::RAM_RW-1:0]
                             : q_head.lane_row[j][cmbd_pkg::RAM_RW-1:0];
    assign par_wa  = clr_act ? clr_row_r[cmbd_pkg::PORT_RW-1:0]
                             : q_head.lane_row[j][cmbd_pkg::PORT_RW-1:0];
    assign rom_wa  = clr_act ? clr_row_r[cmbd_pkg::ROM_RW-1:0]
                             : q_head.lane_row[j][cmbd_pkg::ROM_RW-1:0];
    assign ram_we  = clr_act ? ram_clr_in : (lane_wr && h_ram);
    assign par_we  = clr_act ? par_clr_in : (lane_wr && h_par);
    assign rom_we  = clr_act ? rom_clr_in : (lane_wr && h_rom);

    // Main RAM lane
    always_ff @(posedge clk) begin
      if (ram_we) begin
        ram_m[ram_wa] <= wd;
      end
      if (issue) begin
        ram_q <= ram_m[q_head.lane_row[j][cmbd_pkg::RAM_RW-1:0]];
      end
    end

    // Parallel store lane
    always_ff @(posedge clk) begin
      if (par_we) begin
        par_m[par_wa] <= wd;
      end
      if (issue) begin
        par_q <= par_m[q_head.lane_row[j][cmbd_pkg::PORT_RW-1:0]];
      end
    end

    // Scratchpad lane, no clearing
    always_ff @(posedge clk) begin
      if (lane_wr && h_scr) begin
        scr_m[q_head.lane_row[j][cmbd_pkg::SCR_RW-1:0]] <= q_head.lane_wdata[j];
      end
      if (issue) begin
        scr_q <= scr_m[q_head.lane_row[j][cmbd_pkg::SCR_RW-1:0]];
      end
    end

    // BIOS lane
    always_ff @(posedge clk) begin
      if (rom_we) begin
        rom_m[rom_wa] <= wd;
      end
      if (issue) begin
        rom_q <= rom_m[q_head.lane_row[j][cmbd_pkg::ROM_RW-1:0]];
      end
    end

    // Lane read select by the target of the access in flight
    always_comb begin
      case (cur_r.tgt)
        cmbd_pkg::TGT_RAM:  lane_rd[j] = ram_q;
        cmbd_pkg::TGT_PAR:  lane_rd[j] = par_q;
        cmbd_pkg::TGT_SCR:  lane_rd[j] = scr_q;
        cmbd_pkg::TGT_BIOS: lane_rd[j] = rom_q;
        default:            lane_rd[j] = 8'h00;
      endcase
    end
  end

  // Rotate lanes back into access byte order, zero beyond the size
  always_comb begin
    rd_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      if (cur_r.rd && cur_r.byte_on[k]) begin
        rd_nxt[8*k +: 8] = lane_rd[2'(cur_r.off_lo + 2'(k))];
      end
    end
  end

  // Sequencer: clear sweep, then issue and respond
  always_comb begin
    state_nxt     = state_r;
    clr_row_nxt   = clr_row_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !res_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == cmbd_pkg::CLR_W'(cmbd_pkg::CLR_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (issue) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      cur_r <= q_head;
    end
    if (state_r == ST_RESP) begin
      out_rd_r  <= rd_nxt;
      out_tgt_r <= cur_r.tgt;
      out_wa_r  <= cur_r.we;
      out_on_r  <= cur_r.ram_on;
    end
  end

  assign res_valid         = out_valid_r;
  assign res_read_data     = out_rd_r;
  assign res_target        = out_tgt_r;
  assign res_write_applied = out_wa_r;
  assign res_ram_writes_on = out_on_r;
  assign stat.clearing     = clr_act;
  assign stat.issue        = issue;

endmodule

// ===== tb/sv/console_memory_bus_decoder_tb.sv =====
// Self-checking testbench for the console memory bus decoder: directed and random bus accesses.
`timescale 1ns / 1ps

module console_memory_bus_decoder_tb;
  import cmbd_pkg::*;

  localparam logic [1:0] OP_IDLE = 2'd3;  // fourth opcode does nothing
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_WIDE = 2'd3;  // unused size code, behaves as a word
  localparam int RANDOM_ITEMS = 1725;
  localparam int CYCLE_LIMIT  = 2000000;  // covers the post-reset clearing sweep
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 200;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  size;
    logic [31:0] address;
    logic [31:0] data;
  } bus_access_t;

  typedef struct packed {
    logic [31:0] read_data;
    tgt_t        target;
    logic        write_applied;
    logic        ram_writes_on;
  } bus_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [1:0]  in_access_size;
  logic [31:0] in_address;
  logic [31:0] in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_read_data;
  logic [2:0]  out_target;
  logic        out_write_applied;
  logic        out_ram_writes_on;

  console_memory_bus_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_access_size    (in_access_size),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_target        (out_target),
    .out_write_applied (out_write_applied),
    .out_ram_writes_on (out_ram_writes_on)
  );

  // Shadow copies of the stores and the RAM write enable
  bit [7:0] ram_img [RAM_BYTES];
  bit [7:0] par_img [PORT_BYTES];
  bit [7:0] scr_img [SCRATCH_BYTES];
  bit [7:0] rom_img [ROM_BYTES];
  bit       ram_wr_on = 1'b1;

  bit          scr_written [SCRATCH_BYTES];  // generation side: scratch bytes written so far
  bus_access_t pending_q [$];
  bus_result_t due_results [$];

  int  total_items;
  int  beats_in = 0;
  int  mismatch_total = 0;
  int  cycle_count = 0;
  bit  in_taken_q = 1'b0;
  bit  out_taken_q = 1'b0;
  bit  send_live = 1'b0;
  bit  send_calm = 1'b0;
  int  send_gap = 0;
  bit  recv_calm = 1'b0;
  int  recv_wait = 0;
  int  hold_left = 0;
  int  hold_next = 0;

  always #5 clk = ~clk;

  function automatic int unsigned byte_count(logic [1:0] sz);
    if (sz == SZ_BYTE) return 1;
    if (sz == SZ_HALF) return 2;
    return 4;
  endfunction

  // Address map decode
  function automatic tgt_t map_target(bit [31:0] a);
    bit [15:0] page;
    page = a[31:16];
    if (page == PAGE_SCR) return (a[15:0] < SCR_LIMIT) ? TGT_SCR : TGT_HW;
    if (page == PAGE_PAR) return TGT_PAR;
    if ((page & SEG_MASK) == SEG_KUSEG || (page & SEG_MASK) == SEG_KSEG0 ||
        (page & SEG_MASK) == SEG_KSEG1) return TGT_RAM;
    if ((page & BIOS_MASK) == BIOS_KUSEG || (page & BIOS_MASK) == BIOS_KSEG0 ||
        (page & BIOS_MASK) == BIOS_KSEG1) return TGT_BIOS;
    return TGT_NONE;
  endfunction

  // Byte access, wrapping within the selected store
  function automatic bit [7:0] peek_byte(tgt_t t, bit [31:0] a);
    case (t)
      TGT_RAM:  return ram_img[a[RAM_AW-1:0]];
      TGT_PAR:  return par_img[a[PORT_AW-1:0]];
      TGT_SCR:  return scr_img[a[SCR_AW-1:0]];
      TGT_BIOS: return rom_img[a[ROM_AW-1:0]];
      default:  return 8'h00;
    endcase
  endfunction

  function automatic void poke_byte(tgt_t t, bit [31:0] a, bit [7:0] v);
    case (t)
      TGT_RAM:  ram_img[a[RAM_AW-1:0]] = v;
      TGT_PAR:  par_img[a[PORT_AW-1:0]] = v;
      TGT_SCR:  scr_img[a[SCR_AW-1:0]] = v;
      TGT_BIOS: rom_img[a[ROM_AW-1:0]] = v;
      default:  ;
    endcase
  endfunction

  // Result of one access; updates the shadow stores
  function automatic bus_result_t bus_outcome(bus_access_t acc);
    bus_result_t res;
    int unsigned nb;
    res = '0;
    nb = byte_count(acc.size);
    if (acc.opcode == OP_PRELOAD) begin
      res.target = TGT_BIOS;
      for (int k = 0; k < 4; k++) poke_byte(TGT_BIOS, acc.address + k, acc.data[8*k +: 8]);
      res.write_applied = 1'b1;
    end else begin
      res.target = map_target(acc.address);
      if (acc.opcode == OP_READ) begin
        for (int k = 0; k < nb; k++)
          res.read_data[8*k +: 8] = peek_byte(res.target, acc.address + k);
      end else if (acc.opcode == OP_WRITE) begin
        if (res.target == TGT_PAR || res.target == TGT_SCR ||
            (res.target == TGT_RAM && ram_wr_on)) begin
          for (int k = 0; k < nb; k++)
            poke_byte(res.target, acc.address + k, acc.data[8*k +: 8]);
          res.write_applied = 1'b1;
        end else if (nb == 4 && acc.address == CTRL_ADDR) begin
          if (acc.data == CTRL_OFF_A || acc.data == CTRL_OFF_B) ram_wr_on = 1'b0;
          else if (acc.data == CTRL_ON_A || acc.data == CTRL_ON_B) ram_wr_on = 1'b1;
        end
      end
    end
    res.ram_writes_on = ram_wr_on;
    return res;
  endfunction

  // Offsets favor both ends of a store so that reuse and wrap-around are common
  function automatic bit [31:0] pick_off(int unsigned bits);
    bit [31:0] mask;
    mask = (32'h1 << bits) - 1;
    case ($urandom_range(0, 3))
      0:       return $urandom & mask;
      1:       return mask - $urandom_range(0, 31);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  function automatic bit [31:0] pick_address(tgt_t t);
    bit [15:0] seg;
    case (t)
      TGT_RAM: begin
        case ($urandom_range(0, 2))
          0:       seg = SEG_KUSEG;
          1:       seg = SEG_KSEG0;
          default: seg = SEG_KSEG1;
        endcase
        return {seg, 16'h0} | {9'h0, 2'($urandom), 21'(pick_off(21))};
      end
      TGT_PAR: return {PAGE_PAR, 16'(pick_off(16))};
      TGT_SCR: return {PAGE_SCR, 4'h0, 12'(pick_off(12))};
      TGT_HW:  return {PAGE_SCR, 16'($urandom_range(16'h1000, 16'hffff))};
      TGT_BIOS: begin
        case ($urandom_range(0, 2))
          0:       seg = BIOS_KUSEG;
          1:       seg = BIOS_KSEG0;
          default: seg = BIOS_KSEG1;
        endcase
        return {seg, 16'h0} | {13'h0, 19'(pick_off(19))};
      end
      default: return ($urandom_range(0, 7) == 0) ? CTRL_ADDR : $urandom;
    endcase
  endfunction

  function automatic bit [31:0] pick_ctrl_data();
    case ($urandom_range(0, 5))
      0:       return CTRL_OFF_A;
      1:       return CTRL_OFF_B;
      2:       return CTRL_ON_A;
      3:       return CTRL_ON_B;
      4:       return CTRL_ON_A;
      default: return $urandom;
    endcase
  endfunction

  // Queue one access; a scratchpad read of unwritten bytes gets a write ahead of it
  task automatic queue_access(logic [1:0] op, logic [1:0] sz, logic [31:0] addr,
                              logic [31:0] data);
    bit fresh;
    int unsigned nb;
    fresh = 1'b0;
    nb = byte_count(sz);
    if ((op == OP_READ || op == OP_WRITE) && map_target(addr) == TGT_SCR) begin
      for (int k = 0; k < nb; k++)
        if (!scr_written[(addr + k) % SCRATCH_BYTES]) fresh = 1'b1;
      if (op == OP_READ && fresh) pending_q.push_back({OP_WRITE, sz, addr, 32'($urandom)});
      for (int k = 0; k < nb; k++) scr_written[(addr + k) % SCRATCH_BYTES] = 1'b1;
    end
    pending_q.push_back({op, sz, addr, data});
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  // Stimulus, reset and end of run
  initial begin
    int unsigned roll;
    logic [1:0]  sz;
    logic [31:0] addr;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_READ;
    in_access_size = SZ_BYTE;
    in_address = '0;
    in_write_data = '0;
    out_stall = 1'b0;

    // RAM: reset contents, segment mirrors, wrap at the top of the store, size code 3
    queue_access(OP_READ,  SZ_WORD, 32'h0000_0000, 32'h0);
    queue_access(OP_WRITE, SZ_WORD, 32'h0000_0000, 32'hffff_ffff);
    queue_access(OP_READ,  SZ_BYTE, 32'h8060_0003, 32'h0);
    queue_access(OP_WRITE, SZ_WORD, 32'ha01f_fffe, 32'h1234_5678);
    queue_access(OP_READ,  SZ_WIDE, 32'h001f_fffe, 32'h0);
    // parallel store, wrapping at its end
    queue_access(OP_WRITE, SZ_HALF, 32'h1f00_ffff, 32'h0000_a55a);
    queue_access(OP_READ,  SZ_WORD, 32'h1f00_fffe, 32'h0);
    // scratchpad, wrapping at its end
    queue_access(OP_WRITE, SZ_WORD, 32'h1f80_0ffe, 32'h0bad_f00d);
    queue_access(OP_READ,  SZ_WORD, 32'h1f80_0ffe, 32'h0);
    // hardware forward stores nothing and reads zero
    queue_access(OP_WRITE, SZ_WORD, 32'h1f80_1000, 32'hffff_ffff);
    queue_access(OP_READ,  SZ_BYTE, 32'h1f80_ffff, 32'h0);
    // BIOS preload with wrap, read through a mirror, ignored write
    queue_access(OP_PRELOAD, SZ_BYTE, 32'hffff_fffe, 32'hdead_beef);
    queue_access(OP_READ,  SZ_WORD, 32'hbfc7_fffe, 32'h0);
    queue_access(OP_WRITE, SZ_WORD, 32'h9fc0_0000, 32'h5555_aaaa);
    queue_access(OP_READ,  SZ_HALF, 32'h1fc0_0000, 32'h0);
    // unmapped read
    queue_access(OP_READ,  SZ_WORD, 32'hffff_ffff, 32'h0);
    // RAM write control: off, dropped RAM write, wrong size, unknown data, on, off, on
    queue_access(OP_WRITE, SZ_WORD, CTRL_ADDR, CTRL_OFF_A);
    queue_access(OP_WRITE, SZ_WORD, 32'h0000_0000, 32'h0);
    queue_access(OP_WRITE, SZ_HALF, CTRL_ADDR, CTRL_ON_A);
    queue_access(OP_WRITE, SZ_WORD, CTRL_ADDR, 32'h0000_0801);
    queue_access(OP_WRITE, SZ_WORD, CTRL_ADDR, CTRL_ON_B);
    queue_access(OP_WRITE, SZ_WORD, CTRL_ADDR, CTRL_OFF_B);
    queue_access(OP_WRITE, SZ_WORD, CTRL_ADDR, CTRL_ON_A);
    // no-op opcode
    queue_access(OP_IDLE,  SZ_WIDE, 32'h0000_0000, 32'hffff_ffff);

    // random mix over all regions
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      addr = pick_address(tgt_t'(3'($urandom_range(0, 5))));
      sz = ($urandom_range(0, 9) == 0) ? SZ_WIDE : 2'($urandom_range(0, 2));
      if (roll < 40)
        queue_access(OP_READ, sz, addr, $urandom);
      else if (roll < 78)
        queue_access(OP_WRITE, sz, addr, $urandom);
      else if (roll < 88)
        queue_access(OP_PRELOAD, sz, {13'($urandom), 19'(pick_off(19))}, $urandom);
      else if (roll < 93)
        queue_access(OP_IDLE, sz, addr, $urandom);
      else
        queue_access(OP_WRITE, ($urandom_range(0, 4) == 0) ? 2'($urandom) : SZ_WORD,
                     CTRL_ADDR, pick_ctrl_data());
    end
    total_items = pending_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_in != total_items) @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_total == 0) begin
      $display("console_memory_bus_decoder_tb: done, clean");
    end else begin
      $display("console_memory_bus_decoder_tb: done, errors");
    end
    $finish;
  end

  // Driver: presents queued beats, with random gaps and calm stretches
  always @(negedge clk) begin
    bus_access_t acc;
    if (rst_n) begin
      if (send_live && in_taken_q) begin
        send_live = 1'b0;
        send_gap = send_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      if (!send_live) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_q.size() != 0) begin
          acc = pending_q.pop_front();
          in_opcode <= acc.opcode;
          in_access_size <= acc.size;
          in_address <= acc.address;
          in_write_data <= acc.data;
          send_live = 1'b1;
        end
      end
      in_valid <= send_live;
    end
  end

  // Receiver: random stall after each result beat
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken_q) begin
        recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait != 0) || (hold_left != 0);
    end
  end

  // Long output hold, twice per run, so the input side backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_next < 2 && beats_in >= ((hold_next == 0) ? 300 : 1100)) begin
      hold_left <= HOLD_CYCLES;
      hold_next <= hold_next + 1;
    end
  end

  // Monitor: predicts on input beats, checks result beats in order
  always @(posedge clk) begin
    bus_result_t want;
    if (!rst_n) begin
      in_taken_q <= 1'b0;
      out_taken_q <= 1'b0;
    end else begin
      in_taken_q <= in_valid && !in_stall;
      out_taken_q <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result beat, read_data", 32'h0, out_read_data);
        end else begin
          want = due_results.pop_front();
          if (out_read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, out_read_data);
          if (out_target !== want.target)
            note_mismatch("target", {29'h0, want.target}, {29'h0, out_target});
          if (out_write_applied !== want.write_applied)
            note_mismatch("write_applied", {31'h0, want.write_applied},
                          {31'h0, out_write_applied});
          if (out_ram_writes_on !== want.ram_writes_on)
            note_mismatch("ram_writes_on", {31'h0, want.ram_writes_on},
                          {31'h0, out_ram_writes_on});
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(bus_outcome({in_opcode, in_access_size, in_address,
                                           in_write_data}));
        beats_in++;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("console_memory_bus_decoder_tb: done, errors");
      $finish;
    end
  end

endmodule
